@@ hw/rtl/cpu_subset_bus_core_top_macros.svh @@
// ----------------------------------------------------------------------------
// cpu_subset_bus_core_top_macros.svh
// Assertion macros shared by the bus core RTL.
// ----------------------------------------------------------------------------
`ifndef CPU_SUBSET_BUS_CORE_TOP_MACROS_SVH
`define CPU_SUBSET_BUS_CORE_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define CSCB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define CSCB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/cscb_pkg.sv @@
// ----------------------------------------------------------------------------
// cscb_pkg
// Opcodes, flag positions and sequencer phases of the CPU subset bus core.
// ----------------------------------------------------------------------------
package cscb_pkg;

  // Supported opcodes.
  localparam logic [7:0] OP_BEQ     = 8'hF0;
  localparam logic [7:0] OP_CMP_IMM = 8'hC9;
  localparam logic [7:0] OP_INX     = 8'hE8;
  localparam logic [7:0] OP_LDA_IMM = 8'hA9;
  localparam logic [7:0] OP_LDA_ABX = 8'hBD;
  localparam logic [7:0] OP_LDX_IMM = 8'hA2;
  localparam logic [7:0] OP_STA_ABS = 8'h8D;

  // Address of the first opcode after reset.
  localparam logic [15:0] START_ADDRESS_RESET = 16'h8000;

  // Flag bit positions.
  localparam int unsigned FLAG_N = 2;
  localparam int unsigned FLAG_Z = 1;
  localparam int unsigned FLAG_C = 0;

  // Cycle counts reported at the end of an instruction.
  localparam logic [2:0] CYC_NONE   = 3'd0;
  localparam logic [2:0] CYC_SHORT  = 3'd2;
  localparam logic [2:0] CYC_TAKEN  = 3'd3;
  localparam logic [2:0] CYC_ABS    = 3'd4;
  localparam logic [2:0] CYC_ABS_PX = 3'd5;

  // Bus sequencer phases.
  typedef enum logic [2:0] {
    PH_START  = 3'd0,
    PH_OPCODE = 3'd1,
    PH_IMM    = 3'd2,
    PH_BRANCH = 3'd3,
    PH_ABS_LO = 3'd4,
    PH_ABS_HI = 3'd5,
    PH_DATA   = 3'd6
  } phase_t;

  // Negative and zero flags of a byte, carry kept from the old flags.
  function automatic logic [2:0] set_nz(input logic [2:0] flags, input logic [7:0] v);
    logic [2:0] f;
    f         = flags;
    f[FLAG_N] = v[7];
    f[FLAG_Z] = (v == 8'h00);
    return f;
  endfunction

endpackage

@@ hw/rtl/cpu_subset_bus_core_top.sv @@
// The result is registered at the edge that accepts its request.
// Throughput: one request per cycle; the output register lets a new request
// enter when no result is held or the held result is taken in the same cycle.
// Reset: synchronous, active high; start_address returns to 0x8000 and the
// first request loads the program counter from it and issues the first fetch.
// ----------------------------------------------------------------------------
// cpu_subset_bus_core_top
// Seven-instruction 6502 subset that runs one bus access per request.
// ----------------------------------------------------------------------------
module cpu_subset_bus_core_top
  import cscb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // Configuration write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  // Request channel.
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  read_data,
  // Result channel.
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] bus_address,
  output logic        bus_write,
  output logic [7:0]  write_data,
  output logic        opcode_fetch,
  output logic [2:0]  finished_cycles,
  output logic [7:0]  accumulator_out,
  output logic [7:0]  index_x_out,
  output logic [2:0]  flags_out,
  output logic        illegal
);

`include "cpu_subset_bus_core_top_macros.svh"

  // Architectural and sequencer state.
  logic [15:0] start_address;
  logic [15:0] program_counter, program_counter_next;
  logic [7:0]  accumulator, accumulator_next;
  logic [7:0]  index_x, index_x_next;
  logic [2:0]  flag_bits, flag_bits_next;
  phase_t      phase, phase_next;
  logic [7:0]  opcode_latch, opcode_latch_next;
  logic [7:0]  operand_low, operand_low_next;
  logic        halted, halted_next;
  logic [2:0]  pending_cycles, pending_cycles_next;

  // Result fields before the output register.
  logic [15:0] res_address;
  logic        res_write;
  logic        res_fetch;
  logic [2:0]  res_cycles;

  logic        in_fire;
  logic [15:0] pc_inc;
  logic [15:0] branch_target;
  logic [15:0] abs_base;
  logic [15:0] abs_indexed;
  logic [7:0]  cmp_diff;
  logic        known_op;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign in_fire   = in_valid && in_ready;

  // Shared address arithmetic, compare difference and opcode decode.
  assign pc_inc        = program_counter + 16'd1;
  assign branch_target = pc_inc + {{8{read_data[7]}}, read_data};
  assign abs_base      = {read_data, operand_low};
  assign abs_indexed   = abs_base + {8'h00, index_x};
  assign cmp_diff      = accumulator - read_data;
  assign known_op      = (read_data == OP_INX)     || (read_data == OP_LDA_IMM) ||
                         (read_data == OP_LDX_IMM) || (read_data == OP_CMP_IMM) ||
                         (read_data == OP_BEQ)     || (read_data == OP_LDA_ABX) ||
                         (read_data == OP_STA_ABS);

  // Next phase of the bus sequencer.
  always_comb begin
    phase_next = phase;
    if (!halted) begin
      unique case (phase)
        PH_START:  phase_next = PH_OPCODE;
        PH_OPCODE: begin
          case (read_data) inside
            OP_INX:                             phase_next = PH_OPCODE;
            OP_LDA_IMM, OP_LDX_IMM, OP_CMP_IMM: phase_next = PH_IMM;
            OP_BEQ:                             phase_next = PH_BRANCH;
            OP_LDA_ABX, OP_STA_ABS:             phase_next = PH_ABS_LO;
            default:                            phase_next = PH_OPCODE;
          endcase
        end
        PH_IMM:    phase_next = PH_OPCODE;
        PH_BRANCH: phase_next = PH_OPCODE;
        PH_ABS_LO: phase_next = PH_ABS_HI;
        PH_ABS_HI: phase_next = PH_DATA;
        PH_DATA:   phase_next = PH_OPCODE;
        default:   phase_next = PH_OPCODE;
      endcase
    end
  end

  // Register updates and the bus request issued by this step.
  always_comb begin
    program_counter_next = program_counter;
    accumulator_next     = accumulator;
    index_x_next         = index_x;
    flag_bits_next       = flag_bits;
    opcode_latch_next    = opcode_latch;
    operand_low_next     = operand_low;
    halted_next          = halted;
    pending_cycles_next  = pending_cycles;
    res_address          = program_counter;
    res_write            = 1'b0;
    res_fetch            = 1'b0;
    res_cycles           = CYC_NONE;
    if (!halted) begin
      unique case (phase)
        PH_START: begin
          program_counter_next = start_address;
          res_address          = start_address;
          res_fetch            = 1'b1;
        end
        PH_OPCODE: begin
          opcode_latch_next = read_data;
          if (!known_op) begin
            halted_next = 1'b1;
          end else if (read_data == OP_INX) begin
            program_counter_next = pc_inc;
            index_x_next         = index_x + 8'd1;
            flag_bits_next       = set_nz(flag_bits, index_x + 8'd1);
            res_address          = pc_inc;
            res_fetch            = 1'b1;
            res_cycles           = CYC_SHORT;
          end else begin
            program_counter_next = pc_inc;
            res_address          = pc_inc;
          end
        end
        PH_IMM: begin
          program_counter_next = pc_inc;
          res_address          = pc_inc;
          res_fetch            = 1'b1;
          res_cycles           = CYC_SHORT;
          if (opcode_latch == OP_LDA_IMM) begin
            accumulator_next = read_data;
            flag_bits_next   = set_nz(flag_bits, read_data);
          end else if (opcode_latch == OP_LDX_IMM) begin
            index_x_next   = read_data;
            flag_bits_next = set_nz(flag_bits, read_data);
          end else begin
            flag_bits_next         = set_nz(flag_bits, cmp_diff);
            flag_bits_next[FLAG_C] = (read_data <= accumulator);
          end
        end
        PH_BRANCH: begin
          res_fetch = 1'b1;
          if (flag_bits[FLAG_Z]) begin
            program_counter_next = branch_target;
            res_address          = branch_target;
            res_cycles = (branch_target[15:8] == pc_inc[15:8]) ? CYC_TAKEN : CYC_ABS;
          end else begin
            program_counter_next = pc_inc;
            res_address          = pc_inc;
            res_cycles           = CYC_SHORT;
          end
        end
        PH_ABS_LO: begin
          operand_low_next     = read_data;
          program_counter_next = pc_inc;
          res_address          = pc_inc;
        end
        PH_ABS_HI: begin
          program_counter_next = pc_inc;
          if (opcode_latch == OP_STA_ABS) begin
            pending_cycles_next = CYC_ABS;
            res_address         = abs_base;
            res_write           = 1'b1;
          end else begin
            pending_cycles_next =
              (abs_indexed[15:8] == read_data) ? CYC_ABS : CYC_ABS_PX;
            res_address = abs_indexed;
          end
        end
        PH_DATA: begin
          if (opcode_latch == OP_LDA_ABX) begin
            accumulator_next = read_data;
            flag_bits_next   = set_nz(flag_bits, read_data);
          end
          res_fetch  = 1'b1;
          res_cycles = pending_cycles;
        end
        default: begin
          // Unused phase code restarts at the start address.
          program_counter_next = start_address;
          res_address          = start_address;
          res_fetch            = 1'b1;
        end
      endcase
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      start_address <= START_ADDRESS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      start_address <= cfg_data;
    end
  end

  // Architectural state advances once per accepted request.
  always_ff @(posedge clk) begin
    if (rst) begin
      program_counter <= START_ADDRESS_RESET;
      accumulator     <= 8'h00;
      index_x         <= 8'h00;
      flag_bits       <= 3'b000;
      phase           <= PH_START;
      opcode_latch    <= 8'h00;
      operand_low     <= 8'h00;
      halted          <= 1'b0;
      pending_cycles  <= CYC_NONE;
    end else if (in_fire) begin
      program_counter <= program_counter_next;
      accumulator     <= accumulator_next;
      index_x         <= index_x_next;
      flag_bits       <= flag_bits_next;
      phase           <= phase_next;
      opcode_latch    <= opcode_latch_next;
      operand_low     <= operand_low_next;
      halted          <= halted_next;
      pending_cycles  <= pending_cycles_next;
    end
  end

  // Output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      bus_address     <= res_address;
      bus_write       <= res_write;
      write_data      <= res_write ? accumulator : 8'h00;
      opcode_fetch    <= res_fetch;
      finished_cycles <= res_cycles;
      accumulator_out <= accumulator_next;
      index_x_out     <= index_x_next;
      flags_out       <= flag_bits_next;
      illegal         <= halted_next;
    end
  end

  // Checks on the sequencer.
  `CSCB_ASSERT_NEXT(a_halt_sticks, halted, halted, "halted state was left without reset")
  `CSCB_ASSERT_NOW(a_write_not_fetch, out_valid && bus_write, !opcode_fetch, "write marked as fetch")
  `CSCB_ASSERT_NOW(a_cycles_on_fetch, out_valid && !opcode_fetch, finished_cycles == CYC_NONE, "cycle count without fetch")
  `CSCB_ASSERT_NEXT(a_halt_result, in_fire && halted, out_valid && !opcode_fetch && !bus_write, "halted request issued fetch or write")

endmodule
